FILE: rtl/assert_macros.svh
// Assertion helpers for the top-level RTL file, which carries the checks.
// Each macro builds one labeled concurrent assertion, clocked on the
// rising edge and disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/bbrc_pkg.sv
// ----------------------------------------------------------------------------
// bbrc_pkg
// Types, codes and constants shared by the backoff retry controller files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bbrc_pkg;

  // Field widths.
  localparam int TIME_BITS = 48;
  localparam int BACKOFF_W = 32;
  localparam int ATTEMPT_W = 11;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int SUM_W = ((TIME_BITS > BACKOFF_W) ? TIME_BITS : BACKOFF_W) + 1;

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
  localparam logic [ATTEMPT_W-1:0] ATTEMPT_CAP = ATTEMPT_W'(1024);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_BACKOFF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BACKOFF = 2'd2;

  // Configuration reset values.
  localparam logic [ATTEMPT_W-1:0] MAX_ATTEMPTS_RST = ATTEMPT_W'(3);
  localparam logic [BACKOFF_W-1:0] INIT_BACKOFF_RST = BACKOFF_W'(100);
  localparam logic [BACKOFF_W-1:0] MAX_BACKOFF_RST = BACKOFF_W'(10000);

  // Event kinds.
  localparam logic [1:0] KIND_BEGIN = 2'd0;
  localparam logic [1:0] KIND_ACK = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  // Failure codes.
  localparam logic [2:0] FC_OK = 3'd0;
  localparam logic [2:0] FC_UNAVAILABLE = 3'd1;
  localparam logic [2:0] FC_RES_EXHAUSTED = 3'd3;
  localparam logic [2:0] FC_OTHER = 3'd4;

  // Status codes.
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_TERMINAL = 3'd1;
  localparam logic [2:0] ST_ACTIVE = 3'd2;
  localparam logic [2:0] ST_BACKOFF = 3'd3;
  localparam logic [2:0] ST_BUDGET = 3'd4;
  localparam logic [2:0] ST_NO_ACTIVE = 3'd5;
  localparam logic [2:0] ST_FAIL_OK = 3'd6;
  localparam logic [2:0] ST_BAD_CONFIG = 3'd7;

  typedef enum logic [2:0] {
    PH_READY = 3'd0,
    PH_ACTIVE = 3'd1,
    PH_BACKOFF = 3'd2,
    PH_SUCCEEDED = 3'd3,
    PH_FAILED = 3'd4
  } phase_t;

  // Retry owner state.
  typedef struct packed {
    phase_t                phase;
    logic [ATTEMPT_W-1:0]  attempts;
    logic [BACKOFF_W-1:0]  backoff;
    logic [TIME_BITS-1:0]  deadline;
    logic                  dl_held;
    logic [2:0]            last_code;
    logic                  lc_held;
  } bbrc_state_t;

  // Configuration registers.
  typedef struct packed {
    logic [ATTEMPT_W-1:0] max_attempts;
    logic [BACKOFF_W-1:0] init_backoff;
    logic [BACKOFF_W-1:0] max_backoff;
  } bbrc_cfg_t;

  localparam bbrc_state_t STATE_RST = '{
    phase:     PH_READY,
    attempts:  '0,
    backoff:   INIT_BACKOFF_RST,
    deadline:  '0,
    dl_held:   1'b0,
    last_code: FC_OK,
    lc_held:   1'b0
  };

endpackage

`default_nettype wire

FILE: rtl/bounded_backoff_retry_controller_top.sv
// ----------------------------------------------------------------------------
// bounded_backoff_retry_controller_top
// Retry owner for one delivery with capped exponential backoff.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on the in_ channel (valid/ready): kind, failure_code, now.
//   Every accepted event gives exactly one result transaction on the out_
//   channel: a status and a snapshot of the owner state after the event.
//   An accepted event waits in the input register; its result is then
//   registered in the output register once that register is free.
//   Throughput: one event per cycle while out_ready holds; the state register
//   feeds back through one compare, one 49-bit add and one shift.
//   The input register and the output register are decoupled: an event is
//   taken while a finished result still waits, and when the receiver stalls
//   the input stage fills and in_ready then drops until out_ready returns.
//   Configuration registers are written through cfg_wr_en, cfg_index and
//   cfg_wdata while no event is in flight; a write of the first backoff
//   delay also reloads the current backoff while no attempt has started.
//   Reset (synchronous, active low) empties both stages, returns the owner
//   to the ready phase and restores the register defaults (3, 100, 10000).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bounded_backoff_retry_controller_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Event channel.
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [1:0]                           in_kind,
  input  wire logic [2:0]                           in_failure_code,
  input  wire logic [bbrc_pkg::TIME_BITS-1:0]       in_now,
  // Result channel.
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [2:0]                                out_status,
  output logic [bbrc_pkg::ATTEMPT_W-1:0]            out_attempt_number,
  output logic [2:0]                                out_phase_out,
  output logic [bbrc_pkg::TIME_BITS-1:0]            out_deadline_out,
  output logic                                      out_deadline_valid,
  output logic [2:0]                                out_last_code_out,
  output logic                                      out_last_code_valid,
  // Configuration write port.
  input  wire logic                                 cfg_wr_en,
  input  wire logic [bbrc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [bbrc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  // Input stage registers.
  logic                                 s1_valid_r;
  logic                                 s1_valid_nxt;
  logic [1:0]                           s1_kind_r;
  logic [2:0]                           s1_code_r;
  logic [bbrc_pkg::TIME_BITS-1:0]       s1_now_r;

  // Owner state and configuration.
  bbrc_pkg::bbrc_state_t                st_r;
  bbrc_pkg::bbrc_state_t                st_nxt;
  bbrc_pkg::bbrc_cfg_t                  cfg_r;
  logic [2:0]                           status_nxt;

  // Output stage registers.
  logic                                 out_valid_r;
  logic                                 out_valid_nxt;
  logic [2:0]                           out_status_r;
  bbrc_pkg::bbrc_state_t                out_st_r;

  logic                                 in_fire;
  logic                                 advance;

  // Terms used by the checks.
  logic                                 chk_attempts_ok;
  logic                                 chk_dl_held;
  logic                                 chk_ok_result;
  logic                                 chk_ok_phase;

  // Handshake: the input stage moves on when the output register is free.
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = advance ? 1'b1 : ((out_valid_r && out_ready) ? 1'b0 : out_valid_r);

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_fire) begin
      s1_kind_r <= in_kind;
      s1_code_r <= in_failure_code;
      s1_now_r  <= in_now;
    end
  end

  // Event evaluation.
  bbrc_step u_step (
    .st           (st_r),
    .cfg          (cfg_r),
    .kind         (s1_kind_r),
    .failure_code (s1_code_r),
    .now          (s1_now_r),
    .st_nxt       (st_nxt),
    .status       (status_nxt)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_attempts <= bbrc_pkg::MAX_ATTEMPTS_RST;
      cfg_r.init_backoff <= bbrc_pkg::INIT_BACKOFF_RST;
      cfg_r.max_backoff  <= bbrc_pkg::MAX_BACKOFF_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bbrc_pkg::CFG_MAX_ATTEMPTS: begin
          cfg_r.max_attempts <= cfg_wdata[bbrc_pkg::ATTEMPT_W-1:0];
        end
        bbrc_pkg::CFG_INIT_BACKOFF: begin
          cfg_r.init_backoff <= cfg_wdata[bbrc_pkg::BACKOFF_W-1:0];
        end
        bbrc_pkg::CFG_MAX_BACKOFF: begin
          cfg_r.max_backoff <= cfg_wdata[bbrc_pkg::BACKOFF_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Owner state: updated when an event leaves the input stage; an initial
  // backoff write reloads the current backoff before the first attempt.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= bbrc_pkg::STATE_RST;
    end else if (advance) begin
      st_r <= st_nxt;
    end else if (cfg_wr_en && (cfg_index == bbrc_pkg::CFG_INIT_BACKOFF) &&
                 (st_r.phase == bbrc_pkg::PH_READY) && (st_r.attempts == '0)) begin
      st_r.backoff <= cfg_wdata[bbrc_pkg::BACKOFF_W-1:0];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (advance) begin
      out_status_r <= status_nxt;
      out_st_r     <= st_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_attempt_number  = out_st_r.attempts;
  assign out_phase_out       = out_st_r.phase;
  assign out_deadline_out    = out_st_r.deadline;
  assign out_deadline_valid  = out_st_r.dl_held;
  assign out_last_code_out   = out_st_r.last_code;
  assign out_last_code_valid = out_st_r.lc_held;

  // Conditions checked on a valid result.
  assign chk_attempts_ok = (out_st_r.attempts <= bbrc_pkg::ATTEMPT_CAP);
  assign chk_dl_held     = out_valid_r && out_st_r.dl_held;
  assign chk_ok_result   = out_valid_r && (out_status_r == bbrc_pkg::ST_OK);
  assign chk_ok_phase    = (out_st_r.phase == bbrc_pkg::PH_ACTIVE) ||
                           (out_st_r.phase == bbrc_pkg::PH_SUCCEEDED);

  // Checks on the owner logic.
  `ASSERT_SAME_CYCLE(a_attempts_capped, clk, rst_n, out_valid_r, chk_attempts_ok)
  `ASSERT_SAME_CYCLE(a_deadline_in_backoff, clk, rst_n, chk_dl_held, out_st_r.phase == bbrc_pkg::PH_BACKOFF)
  `ASSERT_SAME_CYCLE(a_ok_phase, clk, rst_n, chk_ok_result, chk_ok_phase)
  `ASSERT_NEXT_CYCLE(a_advance_fills_out, clk, rst_n, advance, out_valid_r)

endmodule

`default_nettype wire

FILE: rtl/bbrc_step.sv
// ----------------------------------------------------------------------------
// bbrc_step
// Event evaluation: applies one begin, acknowledge or failure event to the
// retry owner state and produces the status and the next state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbrc_step (
  input  var bbrc_pkg::bbrc_state_t            st,
  input  var bbrc_pkg::bbrc_cfg_t              cfg,
  input  wire logic [1:0]                      kind,
  input  wire logic [2:0]                      failure_code,
  input  wire logic [bbrc_pkg::TIME_BITS-1:0]  now,
  output bbrc_pkg::bbrc_state_t                st_nxt,
  output logic [2:0]                           status
);

  logic                                cfg_ok;
  logic                                budget_spent;
  logic [2:0]                          code_cap;
  logic                                retryable;
  logic [bbrc_pkg::SUM_W-1:0]          dl_sum;
  logic [bbrc_pkg::TIME_BITS-1:0]      dl_new;
  logic [bbrc_pkg::BACKOFF_W-1:0]      backoff_dbl;

  // Configuration sanity check.
  assign cfg_ok = (cfg.max_attempts != '0) && (cfg.max_attempts <= bbrc_pkg::ATTEMPT_CAP) &&
                  (cfg.init_backoff != '0) && (cfg.max_backoff >= cfg.init_backoff);

  assign budget_spent = (st.attempts >= cfg.max_attempts);

  // Undefined failure codes fold into the non-retryable "other" code.
  assign code_cap  = (failure_code > bbrc_pkg::FC_OTHER) ? bbrc_pkg::FC_OTHER : failure_code;
  assign retryable = (code_cap >= bbrc_pkg::FC_UNAVAILABLE) &&
                     (code_cap <= bbrc_pkg::FC_RES_EXHAUSTED);

  // Deadline is now plus the current backoff, saturating at the time maximum.
  assign dl_sum = bbrc_pkg::SUM_W'(now) + bbrc_pkg::SUM_W'(st.backoff);
  assign dl_new = (dl_sum > bbrc_pkg::SUM_W'(bbrc_pkg::TIME_MAX)) ?
                  bbrc_pkg::TIME_MAX : dl_sum[bbrc_pkg::TIME_BITS-1:0];

  // Doubling capped at the maximum; above half the cap it goes to the cap.
  always_comb begin
    if (st.backoff >= cfg.max_backoff) begin
      backoff_dbl = st.backoff;
    end else if (st.backoff > (cfg.max_backoff >> 1)) begin
      backoff_dbl = cfg.max_backoff;
    end else begin
      backoff_dbl = st.backoff << 1;
    end
  end

  // Event decode and state update.
  always_comb begin
    st_nxt = st;
    status = bbrc_pkg::ST_NO_ACTIVE;
    if (!cfg_ok) begin
      status = bbrc_pkg::ST_BAD_CONFIG;
    end else begin
      case (kind)
        bbrc_pkg::KIND_BEGIN: begin
          priority if ((st.phase == bbrc_pkg::PH_SUCCEEDED) ||
                       (st.phase == bbrc_pkg::PH_FAILED)) begin
            status = bbrc_pkg::ST_TERMINAL;
          end else if (st.phase == bbrc_pkg::PH_ACTIVE) begin
            status = bbrc_pkg::ST_ACTIVE;
          end else if ((st.phase == bbrc_pkg::PH_BACKOFF) && st.dl_held &&
                       (now < st.deadline)) begin
            status = bbrc_pkg::ST_BACKOFF;
          end else if (budget_spent) begin
            status = bbrc_pkg::ST_BUDGET;
          end else begin
            status          = bbrc_pkg::ST_OK;
            st_nxt.attempts = st.attempts + 1'b1;
            st_nxt.phase    = bbrc_pkg::PH_ACTIVE;
            st_nxt.dl_held  = 1'b0;
            st_nxt.deadline = '0;
          end
        end
        bbrc_pkg::KIND_ACK: begin
          if (st.phase == bbrc_pkg::PH_ACTIVE) begin
            status           = bbrc_pkg::ST_OK;
            st_nxt.phase     = bbrc_pkg::PH_SUCCEEDED;
            st_nxt.last_code = bbrc_pkg::FC_OK;
            st_nxt.lc_held   = 1'b1;
            st_nxt.dl_held   = 1'b0;
            st_nxt.deadline  = '0;
          end
        end
        bbrc_pkg::KIND_FAIL: begin
          if ((st.phase == bbrc_pkg::PH_ACTIVE) && (failure_code != bbrc_pkg::FC_OK)) begin
            status           = bbrc_pkg::ST_FAIL_OK;
            st_nxt.last_code = code_cap;
            st_nxt.lc_held   = 1'b1;
            if (!retryable || budget_spent) begin
              st_nxt.phase    = bbrc_pkg::PH_FAILED;
              st_nxt.dl_held  = 1'b0;
              st_nxt.deadline = '0;
            end else begin
              st_nxt.phase    = bbrc_pkg::PH_BACKOFF;
              st_nxt.deadline = dl_new;
              st_nxt.dl_held  = 1'b1;
              st_nxt.backoff  = backoff_dbl;
            end
          end
        end
        default: begin
          status = bbrc_pkg::ST_NO_ACTIVE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for bounded_backoff_retry_controller_top
// Drives retry events through the valid/ready channel with random gaps and
// back-pressure. A local model of the retry owner predicts every result,
// and each result transaction is compared field by field with the oldest
// prediction. The run covers reset defaults, broken register settings,
// deadline saturation, budget lowering and long randomized retry chains
// under many backoff settings. It ends with the owner in a terminal phase.
// ----------------------------------------------------------------------------
module testbench;
  import bbrc_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_EVENTS  = 1400;
  localparam int SETTLE_CYCLES  = 4;

  // Codes that the package leaves unnamed.
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;
  localparam logic [2:0] FC_IO_ERROR  = 3'd2;
  localparam logic [2:0] FC_RAW_MAX   = 3'd7;

  // One result transaction as seen on the out_ channel.
  typedef struct packed {
    logic [2:0]           status;
    logic [ATTEMPT_W-1:0] attempts;
    logic [2:0]           phase;
    logic [TIME_BITS-1:0] deadline;
    logic                 deadline_valid;
    logic [2:0]           last_code;
    logic                 last_code_valid;
  } owner_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            in_kind;
  logic [2:0]            in_failure_code;
  logic [TIME_BITS-1:0]  in_now;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [2:0]            out_status;
  logic [ATTEMPT_W-1:0]  out_attempt_number;
  logic [2:0]            out_phase_out;
  logic [TIME_BITS-1:0]  out_deadline_out;
  logic                  out_deadline_valid;
  logic [2:0]            out_last_code_out;
  logic                  out_last_code_valid;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Model of the register file.
  logic [ATTEMPT_W-1:0]  cfg_max_attempts = MAX_ATTEMPTS_RST;
  logic [BACKOFF_W-1:0]  cfg_init_backoff = INIT_BACKOFF_RST;
  logic [BACKOFF_W-1:0]  cfg_max_backoff  = MAX_BACKOFF_RST;

  // Model of the retry owner.
  phase_t                owner_phase    = PH_READY;
  logic [ATTEMPT_W-1:0]  attempts_done  = '0;
  logic [BACKOFF_W-1:0]  cur_backoff    = INIT_BACKOFF_RST;
  logic [TIME_BITS-1:0]  retry_deadline = '0;
  logic                  dl_held        = 1'b0;
  logic [2:0]            last_code      = FC_OK;
  logic                  code_held      = 1'b0;

  owner_result_t pending_results[$];
  bit  idle_on       = 1'b1;
  bit  result_taken  = 1'b0;
  int  hold_left     = 0;
  int  quiet_cycles  = 0;
  int  mismatches    = 0;
  int  events_sent   = 0;
  int  results_seen  = 0;
  int  settings_used = 0;
  int  status_seen[8];

  bounded_backoff_retry_controller_top DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_failure_code     (in_failure_code),
    .in_now              (in_now),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_attempt_number  (out_attempt_number),
    .out_phase_out       (out_phase_out),
    .out_deadline_out    (out_deadline_out),
    .out_deadline_valid  (out_deadline_valid),
    .out_last_code_out   (out_last_code_out),
    .out_last_code_valid (out_last_code_valid),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // The register settings are usable only within their documented ranges.
  function automatic bit config_valid();
    return cfg_max_attempts != '0 && cfg_max_attempts <= ATTEMPT_CAP &&
           cfg_init_backoff != '0 && cfg_max_backoff >= cfg_init_backoff;
  endfunction

  // Applies one event to the owner model and returns the result it causes.
  function automatic owner_result_t advance_owner(logic [1:0] kind,
                                                  logic [2:0] code,
                                                  logic [TIME_BITS-1:0] now);
    owner_result_t res;
    logic [2:0]    st;
    logic [2:0]    eff_code;
    logic          retry_ok;
    logic [TIME_BITS:0] sum;
    st       = ST_NO_ACTIVE;
    eff_code = (code > FC_OTHER) ? FC_OTHER : code;
    retry_ok = eff_code == FC_UNAVAILABLE || eff_code == FC_IO_ERROR ||
               eff_code == FC_RES_EXHAUSTED;
    sum      = now + cur_backoff;
    if (!config_valid()) begin
      st = ST_BAD_CONFIG;
    end else begin
      case (kind)
        KIND_BEGIN: begin
          if (owner_phase == PH_SUCCEEDED || owner_phase == PH_FAILED) begin
            st = ST_TERMINAL;
          end else if (owner_phase == PH_ACTIVE) begin
            st = ST_ACTIVE;
          end else if (owner_phase == PH_BACKOFF && dl_held && now < retry_deadline) begin
            st = ST_BACKOFF;
          end else if (attempts_done >= cfg_max_attempts) begin
            st = ST_BUDGET;
          end else begin
            attempts_done++;
            owner_phase    = PH_ACTIVE;
            dl_held        = 1'b0;
            retry_deadline = '0;
            st             = ST_OK;
          end
        end
        KIND_ACK: begin
          if (owner_phase == PH_ACTIVE) begin
            owner_phase    = PH_SUCCEEDED;
            last_code      = FC_OK;
            code_held      = 1'b1;
            dl_held        = 1'b0;
            retry_deadline = '0;
            st             = ST_OK;
          end
        end
        KIND_FAIL: begin
          if (owner_phase == PH_ACTIVE && code != FC_OK) begin
            last_code = eff_code;
            code_held = 1'b1;
            st        = ST_FAIL_OK;
            if (!retry_ok || attempts_done >= cfg_max_attempts) begin
              owner_phase    = PH_FAILED;
              dl_held        = 1'b0;
              retry_deadline = '0;
            end else begin
              // Deadline saturates; the backoff doubles up to the cap.
              owner_phase    = PH_BACKOFF;
              retry_deadline = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
              dl_held        = 1'b1;
              if (cur_backoff < cfg_max_backoff) begin
                cur_backoff = (cur_backoff > (cfg_max_backoff >> 1)) ?
                              cfg_max_backoff : (cur_backoff << 1);
              end
            end
          end
        end
        default: ;
      endcase
    end
    res.status          = st;
    res.attempts        = attempts_done;
    res.phase           = owner_phase;
    res.deadline        = dl_held ? retry_deadline : '0;
    res.deadline_valid  = dl_held;
    res.last_code       = code_held ? last_code : FC_OK;
    res.last_code_valid = code_held;
    return res;
  endfunction

  function automatic int draw_wait();
    if (!idle_on || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  // Mix of full-width, near-maximum and small time stamps.
  function automatic logic [TIME_BITS-1:0] random_time();
    logic [63:0] wide;
    int unsigned roll;
    wide = {$urandom(), $urandom()};
    roll = $urandom_range(0, 9);
    if (roll < 3) return wide[TIME_BITS-1:0];
    if (roll == 3) return TIME_MAX - wide[11:0];
    return wide[23:0];
  endfunction

  // Time stamp for a begin: mostly at or past the retry deadline.
  function automatic logic [TIME_BITS-1:0] begin_time();
    logic [TIME_BITS:0] later;
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (owner_phase != PH_BACKOFF || !dl_held || roll < 2) return random_time();
    if (roll < 4 && retry_deadline != '0) return retry_deadline - 1;
    if (roll < 7) return retry_deadline;
    later = retry_deadline + $urandom_range(0, 500);
    return later[TIME_BITS] ? TIME_MAX : later[TIME_BITS-1:0];
  endfunction

  // Sends one event transaction and records its predicted result.
  task automatic send_event(logic [1:0] kind, logic [2:0] code,
                            logic [TIME_BITS-1:0] now);
    int gap;
    gap = draw_wait();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_failure_code <= code;
    in_now          <= now;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(advance_owner(kind, code, now));
    events_sent++;
  endtask

  // Stops the event stream and waits until every result has been checked.
  task automatic drain_events();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_MAX_ATTEMPTS: cfg_max_attempts = data[ATTEMPT_W-1:0];
      CFG_INIT_BACKOFF: begin
        cfg_init_backoff = data;
        // The running backoff follows the register until the first attempt.
        if (owner_phase == PH_READY && attempts_done == '0) cur_backoff = data;
      end
      CFG_MAX_BACKOFF: cfg_max_backoff = data;
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [CFG_DATA_W-1:0] attempts_cap,
                                logic [CFG_DATA_W-1:0] first_delay,
                                logic [CFG_DATA_W-1:0] delay_cap);
    drain_events();
    write_reg(CFG_MAX_ATTEMPTS, attempts_cap);
    write_reg(CFG_INIT_BACKOFF, first_delay);
    write_reg(CFG_MAX_BACKOFF, delay_cap);
    settings_used++;
  endtask

  // Picks an event that keeps the owner alive, with some noise mixed in.
  task automatic send_random_event();
    logic [1:0]           kind;
    logic [2:0]           code;
    logic [TIME_BITS-1:0] stamp;
    int unsigned          roll;
    roll  = $urandom_range(0, 99);
    stamp = random_time();
    code  = $urandom_range(FC_OK, FC_RAW_MAX);
    if (!config_valid() || owner_phase == PH_SUCCEEDED || owner_phase == PH_FAILED) begin
      kind = $urandom_range(KIND_BEGIN, KIND_UNKNOWN);
    end else if (owner_phase == PH_ACTIVE) begin
      if (roll < 70 && attempts_done < cfg_max_attempts) begin
        kind = KIND_FAIL;
        code = $urandom_range(FC_UNAVAILABLE, FC_RES_EXHAUSTED);
      end else if (roll < 80) begin
        kind = KIND_BEGIN;
      end else if (roll < 90) begin
        kind = KIND_FAIL;
        code = FC_OK;
      end else begin
        kind = KIND_UNKNOWN;
      end
    end else begin
      if (roll < 70) begin
        kind  = KIND_BEGIN;
        stamp = begin_time();
      end else if (roll < 80) begin
        kind = KIND_ACK;
      end else if (roll < 90) begin
        kind = KIND_FAIL;
      end else begin
        kind = KIND_UNKNOWN;
      end
    end
    send_event(kind, code, stamp);
  endtask

  // Events in the ready phase that start nothing.
  task automatic test_idle_events();
    send_event(KIND_ACK, FC_OK, '0);
    send_event(KIND_FAIL, FC_RAW_MAX, TIME_MAX);
    send_event(KIND_UNKNOWN, FC_UNAVAILABLE, '0);
  endtask

  // Every broken register setting answers bad config and changes nothing.
  task automatic test_bad_config();
    apply_settings('0, INIT_BACKOFF_RST, MAX_BACKOFF_RST);
    send_event(KIND_BEGIN, FC_OK, '0);
    send_event(KIND_FAIL, FC_OTHER, 48'd77);
    apply_settings(32'h0000_07FF, INIT_BACKOFF_RST, MAX_BACKOFF_RST);
    send_event(KIND_ACK, FC_OK, '0);
    send_event(KIND_UNKNOWN, FC_OTHER, TIME_MAX);
    apply_settings(MAX_ATTEMPTS_RST, '0, MAX_BACKOFF_RST);
    send_event(KIND_BEGIN, FC_OK, 48'd1);
    send_event(KIND_FAIL, FC_UNAVAILABLE, 48'd1);
    apply_settings(MAX_ATTEMPTS_RST, INIT_BACKOFF_RST, 32'd50);
    send_event(KIND_BEGIN, FC_OK, '0);
    send_event(KIND_ACK, FC_OK, '0);
  endtask

  // Backoff reload before the first attempt, active-phase noise and
  // deadlines at the top of the time range.
  task automatic test_first_attempts();
    // Upper write data bits above the attempt field are dropped.
    apply_settings(32'hFFFF_F803, 32'd1, MAX_BACKOFF_RST);
    send_event(KIND_BEGIN, FC_OK, '0);
    send_event(KIND_BEGIN, FC_OK, 48'd5);
    send_event(KIND_FAIL, FC_OK, 48'd5);
    send_event(KIND_UNKNOWN, FC_UNAVAILABLE, TIME_MAX);
    send_event(KIND_FAIL, FC_UNAVAILABLE, TIME_MAX);
    send_event(KIND_BEGIN, FC_OK, TIME_MAX - 1);
    send_event(KIND_ACK, FC_OK, '0);
    send_event(KIND_BEGIN, FC_OK, TIME_MAX);
    send_event(KIND_FAIL, FC_IO_ERROR, TIME_MAX - 2);
    send_event(KIND_BEGIN, FC_OK, TIME_MAX);
  endtask

  // A budget lowered during backoff refuses the next begin.
  task automatic test_budget_lowering();
    apply_settings(ATTEMPT_CAP, 32'd1, MAX_BACKOFF_RST);
    send_event(KIND_FAIL, FC_RES_EXHAUSTED, 48'd100);
    drain_events();
    write_reg(CFG_MAX_ATTEMPTS, 32'd1);
    send_event(KIND_BEGIN, FC_OK, 48'd200);
    drain_events();
    write_reg(CFG_MAX_ATTEMPTS, ATTEMPT_CAP);
    send_event(KIND_BEGIN, FC_OK, 48'd103);
    send_event(KIND_BEGIN, FC_OK, 48'd104);
  endtask

  // Long retry chains under changing settings, idling and back-pressure.
  task automatic test_random_traffic();
    int                   sent;
    int                   span;
    int unsigned          pick;
    int unsigned          shift;
    logic [BACKOFF_W-1:0] cap;
    logic [BACKOFF_W-1:0] base;
    sent = 0;
    while (sent < RANDOM_EVENTS) begin
      pick    = $urandom_range(0, 9);
      span    = $urandom_range(40, 120);
      idle_on = ($urandom_range(0, 3) != 0);
      if (pick == 0) begin
        span = $urandom_range(6, 12);
        case ($urandom_range(0, 3))
          0: apply_settings('0, 32'd1, cfg_max_backoff);
          1: apply_settings($urandom_range(32'd1025, 32'd2047), 32'd1, cfg_max_backoff);
          2: apply_settings(ATTEMPT_CAP, '0, cfg_max_backoff);
          default: begin
            base = $urandom_range(2, 32'hFFFF_FFFF);
            apply_settings(ATTEMPT_CAP, base, $urandom_range(1, base - 1));
          end
        endcase
      end else if (pick == 1) begin
        span = $urandom_range(10, 20);
        apply_settings($urandom_range(1, attempts_done), 32'd1, cfg_max_backoff);
      end else if (pick == 2) begin
        apply_settings(ATTEMPT_CAP, '1, '1);
      end else if (pick == 3) begin
        apply_settings(ATTEMPT_CAP, 32'd1, 32'd1);
      end else begin
        shift = $urandom_range(0, 31);
        cap   = 32'd1 << shift;
        if ($urandom_range(0, 1) == 1) cap = cap + $urandom_range(0, cap - 1);
        base  = $urandom_range(1, cap);
        apply_settings(ATTEMPT_CAP, base, cap);
      end
      repeat (span) send_random_event();
      sent += span;
    end
    idle_on = 1'b1;
  endtask

  // Ends the delivery by one of the terminal paths, then probes the
  // terminal phase.
  task automatic test_terminal_state();
    int unsigned path;
    path = $urandom_range(0, 2);
    apply_settings(ATTEMPT_CAP, 32'd1, '1);
    if (owner_phase == PH_BACKOFF && attempts_done < cfg_max_attempts) begin
      send_event(KIND_BEGIN, FC_OK, TIME_MAX);
    end
    if (owner_phase == PH_ACTIVE) begin
      case (path)
        0: send_event(KIND_ACK, $urandom_range(FC_OK, FC_RAW_MAX), random_time());
        1: send_event(KIND_FAIL, $urandom_range(FC_OTHER, FC_RAW_MAX), random_time());
        default: begin
          // A retryable failure with the budget spent fails the delivery.
          drain_events();
          write_reg(CFG_MAX_ATTEMPTS, attempts_done);
          send_event(KIND_FAIL, FC_UNAVAILABLE, random_time());
        end
      endcase
    end
    send_event(KIND_BEGIN, FC_OK, TIME_MAX);
    send_event(KIND_ACK, FC_OK, '0);
    send_event(KIND_FAIL, FC_IO_ERROR, '0);
    send_event(KIND_UNKNOWN, FC_RAW_MAX, TIME_MAX);
    apply_settings(ATTEMPT_CAP, 32'd5, 32'd4);
    send_event(KIND_BEGIN, FC_OK, '0);
  endtask

  // Result receiver: after each result, holds out_ready low for a randomly drawn wait.
  always @(negedge clk) begin
    if (result_taken) hold_left = draw_wait();
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compares each accepted result transaction with the oldest prediction.
  always @(posedge clk) begin : check_results
    owner_result_t want;
    owner_result_t got;
    result_taken = 1'b0;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      result_taken = 1'b1;
      got = {out_status, out_attempt_number, out_phase_out, out_deadline_out,
             out_deadline_valid, out_last_code_out, out_last_code_valid};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected result at %0t: status %0d, no event pending",
                   $realtime, got.status);
        end
      end else begin
        want = pending_results.pop_front();
        status_seen[got.status]++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch at %0t: expected st %0d att %0d ph %0d dl %h/%0b lc %0d/%0b",
                     $realtime, want.status, want.attempts, want.phase, want.deadline,
                     want.deadline_valid, want.last_code, want.last_code_valid);
            $display("                      got st %0d att %0d ph %0d dl %h/%0b lc %0d/%0b",
                     got.status, got.attempts, got.phase, got.deadline,
                     got.deadline_valid, got.last_code, got.last_code_valid);
          end
        end
      end
    end
  end

  // Watchdog: too long without any transaction ends the run.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_kind         = KIND_BEGIN;
    in_failure_code = FC_OK;
    in_now          = '0;
    cfg_wr_en       = 1'b0;
    cfg_index       = CFG_MAX_ATTEMPTS;
    cfg_wdata       = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_events();
    test_bad_config();
    test_first_attempts();
    test_budget_lowering();
    test_random_traffic();
    test_terminal_state();

    drain_events();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run: %0d events, %0d results, %0d register settings, %0d attempts, final phase %0d",
             events_sent, results_seen, settings_used, attempts_done, owner_phase);
    $display("Statuses: ok %0d term %0d active %0d backoff %0d budget %0d none %0d fail %0d bad %0d",
             status_seen[ST_OK], status_seen[ST_TERMINAL], status_seen[ST_ACTIVE],
             status_seen[ST_BACKOFF], status_seen[ST_BUDGET], status_seen[ST_NO_ACTIVE],
             status_seen[ST_FAIL_OK], status_seen[ST_BAD_CONFIG]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/bbrc_pkg.sv
rtl/bbrc_step.sv
rtl/bounded_backoff_retry_controller_top.sv
dv/testbench.sv
